/* design/nmt_pkg.sv */
// Package for the NAT mapping table: slot entry layout, request and status codes,
// and the port-counter constants. Used by nmt_match, the top level and the checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package nmt_pkg;

    // Request kinds carried on the mode field.
    localparam logic [1:0] MODE_OUT    = 2'd0;
    localparam logic [1:0] MODE_IN     = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_MISS     = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_TICK     = 3'd4;

    // Port counter: starts one below the first dynamic port and wraps back to it.
    localparam logic [15:0] PORT_RESET    = 16'd1023;
    localparam logic [15:0] PORT_FIRST    = 16'd1024;
    localparam logic [15:0] PORT_LAST     = 16'hFFFF;
    localparam logic [15:0] TIMEOUT_RESET = 16'd60;

    // Configuration register indexes.
    localparam logic REG_ICMP_TIMEOUT    = 1'b0;
    localparam logic REG_OUTSIDE_ADDRESS = 1'b1;

    // One table slot as stored in the slot memory.
    typedef struct packed {
        logic        valid;
        logic        is_tcp;
        logic [31:0] inside_addr;
        logic [15:0] inside_port;
        logic [15:0] outside_port;
        logic [31:0] created;
    } slot_entry_t;

    // Compare results for one slot against the request in flight.
    typedef struct packed {
        logic inside_hit;
        logic outside_hit;
        logic expired;
        logic free;
    } match_t;

endpackage

`default_nettype wire

/* design/nmt_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Holds the slot table of the NAT mapping block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module nmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* design/nmt_match.sv */
// Shared compare unit: checks one slot read from the table against the request.
// Uses the entry and match types of nmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nmt_match
    import nmt_pkg::*;
(
    input  wire slot_entry_t  entry,
    input  wire logic         req_tcp,
    input  wire logic [31:0]  req_inside_addr,
    input  wire logic [15:0]  req_inside_port,
    input  wire logic [15:0]  req_outside_port,
    input  wire logic [31:0]  seconds_now,
    input  wire logic [15:0]  age_limit,
    output match_t            result
);

    logic        kind_ok;
    logic [31:0] age;

    // Age wraps modulo 2^32 like the seconds counter itself.
    assign age     = seconds_now - entry.created;
    assign kind_ok = entry.valid && (entry.is_tcp == req_tcp);

    always_comb
    begin
        result.inside_hit  = kind_ok && (entry.inside_addr == req_inside_addr)
                             && (entry.inside_port == req_inside_port);
        result.outside_hit = kind_ok && (entry.outside_port == req_outside_port);
        result.expired     = entry.valid && !entry.is_tcp && (age >= {16'd0, age_limit});
        result.free        = !entry.valid;
    end

endmodule

`default_nettype wire

/* design/nat_mapping_table_top.sv */
// Top level of the NAT mapping table: request sequencer, slot scan, APB registers.
// Depends on nmt_pkg, nmt_ram and nmt_match.
//
//  channel   direction  handshake            payload
//  request   in         in_valid/in_ready    mode, is_tcp, inside_addr, inside_port, outside_port
//  result    out        out_valid/out_ready  status, found_inside_addr/port, found_outside_addr/port
//  config    in         APB psel/penable     paddr, pwdata, prdata (pready tied high)
//
// A request scans every slot through one memory read port and one compare unit;
// modes 0 to 2 go through the slot scan before the result, mode 3 goes straight to the result.
// After reset a clearing pass writes every slot empty, with in_ready low.
// The next request is taken once the previous one has moved into the result register;
// a stalled result holds the sequencer only when the following result is ready to leave.
`timescale 1ns / 1ps
`default_nettype none

module nat_mapping_table_top
    import nmt_pkg::*;
#(
    parameter int TABLE_SLOTS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Request channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  mode,
    input  wire logic        is_tcp,
    input  wire logic [31:0] inside_addr,
    input  wire logic [15:0] inside_port,
    input  wire logic [15:0] outside_port,
    // Result channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [31:0]      found_inside_addr,
    output logic [15:0]      found_inside_port,
    output logic [31:0]      found_outside_addr,
    output logic [15:0]      found_outside_port,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(TABLE_SLOTS);
    localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(TABLE_SLOTS - 1);
    localparam int ENTRY_W = $bits(slot_entry_t);

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_SCAN   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    // Control state
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               hit_found_reg, hit_found_next;
    logic               free_found_reg, free_found_next;
    logic [15:0]        last_port_reg, last_port_next;
    logic [31:0]        seconds_reg, seconds_next;
    logic [15:0]        timeout_reg, timeout_next;
    logic [31:0]        out_addr_reg, out_addr_next;
    logic               out_valid_reg, out_valid_next;

    // Payload state
    logic [1:0]         mode_reg, mode_next;
    logic               tcp_reg, tcp_next;
    logic [31:0]        iaddr_reg, iaddr_next;
    logic [15:0]        iport_reg, iport_next;
    logic [15:0]        oport_reg, oport_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic [31:0]        hit_iaddr_reg, hit_iaddr_next;
    logic [15:0]        hit_iport_reg, hit_iport_next;
    logic [15:0]        hit_oport_reg, hit_oport_next;
    logic [2:0]         status_reg, status_next;
    logic [31:0]        res_iaddr_reg, res_iaddr_next;
    logic [15:0]        res_iport_reg, res_iport_next;
    logic [31:0]        res_oaddr_reg, res_oaddr_next;
    logic [15:0]        res_oport_reg, res_oport_next;

    // Memory and compare unit signals
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    slot_entry_t        wr_entry;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    slot_entry_t        rd_entry;
    match_t             match;
    logic               issue;
    logic               cfg_write;
    logic [15:0]        port_new;

    assign rd_entry = slot_entry_t'(rd_data);

    nmt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (ENTRY_W'(wr_entry)),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    nmt_match u_match (
        .entry            (rd_entry),
        .req_tcp          (tcp_reg),
        .req_inside_addr  (iaddr_reg),
        .req_inside_port  (iport_reg),
        .req_outside_port (oport_reg),
        .seconds_now      (seconds_reg),
        .age_limit        (timeout_reg),
        .result           (match)
    );

    // Next external port: counts up and wraps from the top back to the first dynamic port.
    assign port_new = (last_port_reg == PORT_LAST) ? PORT_FIRST : last_port_reg + 16'd1;

    // APB register file.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_OUTSIDE_ADDRESS) ? out_addr_reg : {16'd0, timeout_reg};

    always_comb
    begin
        timeout_next  = timeout_reg;
        out_addr_next = out_addr_reg;
        if (cfg_write)
        begin
            if (paddr[2] == REG_ICMP_TIMEOUT)
            begin
                timeout_next = pwdata[15:0];
            end
            else
            begin
                out_addr_next = pwdata;
            end
        end
    end

    // Ports.
    assign in_ready           = (state_reg == S_IDLE);
    assign out_valid          = out_valid_reg;
    assign status             = status_reg;
    assign found_inside_addr  = res_iaddr_reg;
    assign found_inside_port  = res_iport_reg;
    assign found_outside_addr = res_oaddr_reg;
    assign found_outside_port = res_oport_reg;

    assign issue = (cnt_reg != SLOTS_CNT);

    // Sequencer: clear pass, idle, slot scan, result hand-off.
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rd_pend_next    = 1'b0;
        rd_idx_next     = rd_idx_reg;
        hit_found_next  = hit_found_reg;
        free_found_next = free_found_reg;
        last_port_next  = last_port_reg;
        seconds_next    = seconds_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        mode_next       = mode_reg;
        tcp_next        = tcp_reg;
        iaddr_next      = iaddr_reg;
        iport_next      = iport_reg;
        oport_next      = oport_reg;
        free_idx_next   = free_idx_reg;
        hit_iaddr_next  = hit_iaddr_reg;
        hit_iport_next  = hit_iport_reg;
        hit_oport_next  = hit_oport_reg;
        status_next     = status_reg;
        res_iaddr_next  = res_iaddr_reg;
        res_iport_next  = res_iport_reg;
        res_oaddr_next  = res_oaddr_reg;
        res_oport_next  = res_oport_reg;

        wr_en           = 1'b0;
        wr_addr         = cnt_reg[IDX_W-1:0];
        wr_entry        = '0;
        rd_en           = 1'b0;
        rd_addr         = cnt_reg[IDX_W-1:0];

        case (state_reg)
            S_CLEAR:
            begin
                // Write one empty slot per cycle.
                wr_en = 1'b1;
                if (cnt_reg == LAST_CNT)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next       = mode;
                    tcp_next        = is_tcp;
                    iaddr_next      = inside_addr;
                    iport_next      = inside_port;
                    oport_next      = outside_port;
                    cnt_next        = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    if (mode == MODE_TICK)
                    begin
                        seconds_next = seconds_reg + 32'd1;
                    end
                    state_next = (mode == MODE_UNUSED) ? S_FINISH : S_SCAN;
                end
            end

            S_SCAN:
            begin
                // Issue the next slot read; the previous one is compared this cycle.
                rd_en        = issue;
                rd_pend_next = issue;
                rd_idx_next  = cnt_reg[IDX_W-1:0];
                if (issue)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end

                if (rd_pend_reg)
                begin
                    if (mode_reg == MODE_OUT)
                    begin
                        if (!hit_found_reg && match.inside_hit)
                        begin
                            hit_found_next = 1'b1;
                            hit_iaddr_next = rd_entry.inside_addr;
                            hit_iport_next = rd_entry.inside_port;
                            hit_oport_next = rd_entry.outside_port;
                        end
                        if (!free_found_reg && match.free)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = rd_idx_reg;
                        end
                    end
                    else if (mode_reg == MODE_IN)
                    begin
                        if (!hit_found_reg && match.outside_hit)
                        begin
                            hit_found_next = 1'b1;
                            hit_iaddr_next = rd_entry.inside_addr;
                            hit_iport_next = rd_entry.inside_port;
                            hit_oport_next = rd_entry.outside_port;
                        end
                    end
                    else if (match.expired)
                    begin
                        // Aged-out ICMP mapping: write it back empty.
                        wr_en          = 1'b1;
                        wr_addr        = rd_idx_reg;
                        wr_entry       = rd_entry;
                        wr_entry.valid = 1'b0;
                    end
                end

                if (!issue && !rd_pend_reg)
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                // Load the result register once it is free or being emptied.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_MISS;
                    res_iaddr_next = '0;
                    res_iport_next = '0;
                    res_oaddr_next = '0;
                    res_oport_next = '0;
                    state_next     = S_IDLE;
                    case (mode_reg)
                        MODE_OUT:
                        begin
                            if (hit_found_reg)
                            begin
                                status_next    = ST_HIT;
                                res_iaddr_next = hit_iaddr_reg;
                                res_iport_next = hit_iport_reg;
                                res_oaddr_next = out_addr_reg;
                                res_oport_next = hit_oport_reg;
                            end
                            else if (free_found_reg)
                            begin
                                status_next         = ST_INSERTED;
                                res_iaddr_next      = iaddr_reg;
                                res_iport_next      = iport_reg;
                                res_oaddr_next      = out_addr_reg;
                                res_oport_next      = port_new;
                                last_port_next      = port_new;
                                wr_en               = 1'b1;
                                wr_addr             = free_idx_reg;
                                wr_entry.valid        = 1'b1;
                                wr_entry.is_tcp       = tcp_reg;
                                wr_entry.inside_addr  = iaddr_reg;
                                wr_entry.inside_port  = iport_reg;
                                wr_entry.outside_port = port_new;
                                wr_entry.created      = seconds_reg;
                            end
                            else
                            begin
                                status_next = ST_FULL;
                            end
                        end
                        MODE_IN:
                        begin
                            if (hit_found_reg)
                            begin
                                status_next    = ST_HIT;
                                res_iaddr_next = hit_iaddr_reg;
                                res_iport_next = hit_iport_reg;
                                res_oaddr_next = out_addr_reg;
                                res_oport_next = hit_oport_reg;
                            end
                        end
                        MODE_TICK:
                        begin
                            status_next = ST_TICK;
                        end
                        default:
                        begin
                            status_next = ST_MISS;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            cnt_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            rd_idx_reg     <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            last_port_reg  <= PORT_RESET;
            seconds_reg    <= '0;
            timeout_reg    <= TIMEOUT_RESET;
            out_addr_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            rd_pend_reg    <= rd_pend_next;
            rd_idx_reg     <= rd_idx_next;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
            last_port_reg  <= last_port_next;
            seconds_reg    <= seconds_next;
            timeout_reg    <= timeout_next;
            out_addr_reg   <= out_addr_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        tcp_reg       <= tcp_next;
        iaddr_reg     <= iaddr_next;
        iport_reg     <= iport_next;
        oport_reg     <= oport_next;
        free_idx_reg  <= free_idx_next;
        hit_iaddr_reg <= hit_iaddr_next;
        hit_iport_reg <= hit_iport_next;
        hit_oport_reg <= hit_oport_next;
        status_reg    <= status_next;
        res_iaddr_reg <= res_iaddr_next;
        res_iport_reg <= res_iport_next;
        res_oaddr_reg <= res_oaddr_next;
        res_oport_reg <= res_oport_next;
    end

endmodule

`default_nettype wire

/* design/nmt_checker.sv */
// Port-level checks for the NAT mapping table, bound to nat_mapping_table_top.
// Depends on nmt_pkg for the status codes.
`timescale 1ns / 1ps
`default_nettype none

module nmt_checker
    import nmt_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  status,
    input wire logic [31:0] found_inside_addr,
    input wire logic [15:0] found_inside_port,
    input wire logic [31:0] found_outside_addr,
    input wire logic [15:0] found_outside_port,
    input wire logic        pready
);

    // A stalled result transaction stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn before it was taken");

    // The sequencer takes one request at a time.
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while the previous one is in flight");

    // Only defined status codes leave the block.
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= ST_TICK))
        else $error("undefined status code");

    // Results without a mapping carry zero fields.
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_MISS || status == ST_FULL || status == ST_TICK)
        |-> (found_inside_addr == '0) && (found_inside_port == '0)
            && (found_outside_addr == '0) && (found_outside_port == '0))
        else $error("nonzero mapping fields on a result without a mapping");

    // The register port never inserts wait states.
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind nat_mapping_table_top nmt_checker u_nmt_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .status             (status),
    .found_inside_addr  (found_inside_addr),
    .found_inside_port  (found_inside_port),
    .found_outside_addr (found_outside_addr),
    .found_outside_port (found_outside_port),
    .pready             (pready)
);

`default_nettype wire
